[sv/mwra_pkg.sv]
// shared types, constants and register indexes for the multi-window ratio average
package mwra_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_HISTORY_DEPTH   = 256;
    localparam int DEF_MAX_WINDOWS     = 4;
    localparam int DEF_RATIO_FRAC_BITS = 16;

    // fixed field widths
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 24;
    localparam int WIN_W      = 16;
    localparam int WCOUNT_W   = 3;
    localparam int WIDX_W     = 2;
    localparam int WIN_REGS   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 3'd4;

    // configuration reset values
    localparam logic [WIN_W-1:0]    WINDOW_0_RST     = 16'd60;
    localparam logic [WIN_W-1:0]    WINDOW_1_RST     = 16'd120;
    localparam logic [WIN_W-1:0]    WINDOW_2_RST     = 16'd300;
    localparam logic [WIN_W-1:0]    WINDOW_3_RST     = 16'd600;
    localparam logic [WCOUNT_W-1:0] WINDOW_COUNT_RST = 3'd1;

    // input item
    typedef struct packed {
        logic [TIME_W-1:0] sample_time;
        logic [VAL_W-1:0]  sample_ratio;
    } t_in;

    // result item
    typedef struct packed {
        logic [WIDX_W-1:0] window_index;
        logic [VAL_W-1:0]  mean_ratio;
        logic [VAL_W-1:0]  inverse_mean;
        logic              last_of_run;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mark_zero;
        logic rd;
        logic step;
        logic win_first;
        logic win_skip;
        logic div_mean;
        logic take_mean;
        logic div_inv;
        logic take_inv;
        logic win_next;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic not_ready;
        logic walk_done;
        logic win_empty;
        logic div_done;
        logic mean_zero;
        logic win_last;
    } t_sts;

endpackage

[sv/mwra_ram.sv]
// generic single write port ram with registered read
module mwra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mwra_div.sv]
// restoring divider, one quotient bit per cycle
module mwra_div #(
    parameter int DW = 33,
    parameter int DV = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DV-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DV-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DV-1:0] r_dvs;
    logic [DV:0]   trial;
    logic [DV:0]   diff;
    logic          ge;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DV-1:0] : trial[DV-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[sv/mwra_dp.sv]
// datapath: config registers, history ring, window sums, divider and result registers
module mwra_dp import mwra_pkg::*; #(
    parameter int HISTORY_DEPTH   = DEF_HISTORY_DEPTH,
    parameter int MAX_WINDOWS     = DEF_MAX_WINDOWS,
    parameter int RATIO_FRAC_BITS = DEF_RATIO_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in                   i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output t_out                  o_out
);

    localparam int AW        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W     = VAL_W + CNT_W;
    localparam int INV_W     = 2 * RATIO_FRAC_BITS + 1;
    localparam int DW        = (SUM_W > INV_W) ? SUM_W : INV_W;
    localparam int DV        = (CNT_W > VAL_W) ? CNT_W : VAL_W;
    localparam int NUM_LANES = (MAX_WINDOWS < WIN_REGS) ? MAX_WINDOWS : WIN_REGS;
    localparam int IN_W      = $bits(t_in);

    localparam logic [WCOUNT_W-1:0] LANES_N  = WCOUNT_W'(NUM_LANES);
    localparam logic [AW-1:0]       LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]    FULL_LVL  = CNT_W'(HISTORY_DEPTH);
    localparam logic [DW-1:0]       INV_NUM   = DW'(1) << (2 * RATIO_FRAC_BITS);

    // configuration
    logic [WIN_W-1:0]    r_win [WIN_REGS];
    logic [WCOUNT_W-1:0] r_wcount;

    // sample state
    logic [AW-1:0]     r_slot;
    logic [CNT_W-1:0]  r_fill;
    logic [TIME_W-1:0] r_oldest;
    logic [TIME_W-1:0] r_now;

    // walk state
    logic [AW-1:0]    r_addr;
    logic [CNT_W-1:0] r_k;
    logic             r_zero;
    logic [SUM_W-1:0] r_sum [NUM_LANES];
    logic [CNT_W-1:0] r_cnt [NUM_LANES];

    // result registers
    logic [WIDX_W-1:0] r_w;
    logic [VAL_W-1:0]  r_mean;
    logic [VAL_W-1:0]  r_inv;

    logic [WCOUNT_W-1:0] use_n;
    logic [WIDX_W-1:0]   n_last;
    logic [WIN_W-1:0]    longest;
    logic [IN_W-1:0]     ram_rdata;
    t_in                 rd;
    logic [TIME_W-1:0]   age;
    logic                age_out;
    logic                ratio_zero;
    logic [NUM_LANES-1:0] hit;
    logic [SUM_W-1:0]    sum_sel;
    logic [CNT_W-1:0]    cnt_sel;
    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic [DV-1:0]       div_divisor;
    logic                div_done;
    logic [DW-1:0]       div_q;
    logic [VAL_W-1:0]    q_clamp;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= WINDOW_0_RST;
            r_win[1] <= WINDOW_1_RST;
            r_win[2] <= WINDOW_2_RST;
            r_win[3] <= WINDOW_3_RST;
            r_wcount <= WINDOW_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_0:     r_win[0] <= i_cfg_data;
                REG_WINDOW_1:     r_win[1] <= i_cfg_data;
                REG_WINDOW_2:     r_win[2] <= i_cfg_data;
                REG_WINDOW_3:     r_win[3] <= i_cfg_data;
                REG_WINDOW_COUNT: r_wcount <= i_cfg_data[WCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // windows in use and longest window
    always_comb begin
        use_n = r_wcount;
        if (use_n == '0) begin
            use_n = WCOUNT_W'(1);
        end
        if (use_n > LANES_N) begin
            use_n = LANES_N;
        end
        n_last  = WIDX_W'(use_n - WCOUNT_W'(1));
        longest = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (WCOUNT_W'(l) < use_n && r_win[l] > longest) begin
                longest = r_win[l];
            end
        end
    end

    // history ring
    mwra_ram #(
        .WIDTH (IN_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_slot),
        .i_wdata (i_in),
        .i_re    (i_cmd.rd),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd         = t_in'(ram_rdata);
    assign age        = r_now - rd.sample_time;
    assign age_out    = age > TIME_W'(longest);
    assign ratio_zero = rd.sample_ratio == '0;

    // per lane window membership
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            hit[l] = (WCOUNT_W'(l) < use_n) && (age <= TIME_W'(r_win[l]));
        end
    end

    // ring pointers and first timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_fill   <= '0;
            r_oldest <= '0;
        end else if (i_cmd.load) begin
            r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            if (r_fill != FULL_LVL) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_fill == '0) begin
                r_oldest <= i_in.sample_time;
            end
        end
    end

    // walk back over the ring, summing per window
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now  <= i_in.sample_time;
            r_addr <= r_slot;
            r_k    <= '0;
            r_zero <= 1'b0;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_sum[l] <= '0;
                r_cnt[l] <= '0;
            end
        end else if (i_cmd.mark_zero) begin
            r_zero <= 1'b1;
        end else if (i_cmd.step && !age_out) begin
            if (ratio_zero) begin
                r_zero <= 1'b1;
            end else begin
                r_addr <= (r_addr == '0) ? LAST_SLOT : r_addr - 1'b1;
                r_k    <= r_k + 1'b1;
                for (int l = 0; l < NUM_LANES; l++) begin
                    if (hit[l]) begin
                        r_sum[l] <= r_sum[l] + SUM_W'(rd.sample_ratio);
                        r_cnt[l] <= r_cnt[l] + 1'b1;
                    end
                end
            end
        end
    end

    // select the current window lane
    always_comb begin
        sum_sel = '0;
        cnt_sel = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_w == WIDX_W'(l)) begin
                sum_sel = r_sum[l];
                cnt_sel = r_cnt[l];
            end
        end
    end

    // shared divider for mean and reciprocal
    assign div_start    = i_cmd.div_mean | i_cmd.div_inv;
    assign div_dividend = i_cmd.div_mean ? DW'(sum_sel) : INV_NUM;
    assign div_divisor  = i_cmd.div_mean ? DV'(cnt_sel) : DV'(q_clamp);

    mwra_div #(
        .DW (DW),
        .DV (DV)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // saturate quotient to the 24 bit range
    assign q_clamp = (|div_q[DW-1:VAL_W]) ? '1 : div_q[VAL_W-1:0];

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.win_first) begin
            r_w <= '0;
        end else if (i_cmd.win_next) begin
            r_w <= r_w + 1'b1;
        end
        if (i_cmd.win_skip) begin
            r_mean <= '0;
            r_inv  <= '0;
        end else if (i_cmd.take_mean) begin
            r_mean <= q_clamp;
            r_inv  <= '0;
        end else if (i_cmd.take_inv) begin
            r_inv <= q_clamp;
        end
    end

    // status
    assign o_sts.not_ready = (r_now - r_oldest) <= TIME_W'(longest);
    assign o_sts.walk_done = age_out || ratio_zero || ((r_k + 1'b1) == r_fill);
    assign o_sts.win_empty = r_zero || (cnt_sel == '0);
    assign o_sts.div_done  = div_done;
    assign o_sts.mean_zero = q_clamp == '0;
    assign o_sts.win_last  = r_w == n_last;

    // result payload
    assign o_out.window_index = r_w;
    assign o_out.mean_ratio   = r_mean;
    assign o_out.inverse_mean = r_inv;
    assign o_out.last_of_run  = r_w == n_last;

endmodule

[sv/mwra_ctrl.sv]
// controller: sequences load, ring walk, divisions and result transfers
module mwra_ctrl import mwra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_STEP  = 8'b0000_1000,
        S_WIN   = 8'b0001_0000,
        S_DIVM  = 8'b0010_0000,
        S_DIVI  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.not_ready) begin
                    o_cmd.mark_zero = 1'b1;
                    o_cmd.win_first = 1'b1;
                    n_state         = S_WIN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_done) begin
                    o_cmd.win_first = 1'b1;
                    n_state         = S_WIN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_WIN: begin
                if (i_sts.win_empty) begin
                    o_cmd.win_skip = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.div_mean = 1'b1;
                    n_state        = S_DIVM;
                end
            end
            S_DIVM: begin
                if (i_sts.div_done) begin
                    o_cmd.take_mean = 1'b1;
                    if (i_sts.mean_zero) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.div_inv = 1'b1;
                        n_state       = S_DIVI;
                    end
                end
            end
            S_DIVI: begin
                if (i_sts.div_done) begin
                    o_cmd.take_inv = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.win_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.win_next = 1'b1;
                        n_state        = S_WIN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/multi_window_ratio_average.sv]
// top level of the multi-window ratio average
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   i_in  (t_in)
//   out       output     o_out_valid / i_out_ready o_out (t_out)
//   cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one sample walks K ring entries and then serves the N windows in use, and its results
// can wait on output stalls; DW is the divider length (33 at defaults)
// a window zeroed by a short history or a zero ratio goes out with no division
// the walk reads the ring memory in S_READ and adds each entry in S_STEP, and one shared
// divider computes each mean and then its reciprocal if nonzero, one quotient bit per cycle
// reset clears pointers and fill level; ring entries beyond the fill are never read
// a sample is taken only when the previous one has delivered all its results
module multi_window_ratio_average import mwra_pkg::*; #(
    parameter int HISTORY_DEPTH   = DEF_HISTORY_DEPTH,
    parameter int MAX_WINDOWS     = DEF_MAX_WINDOWS,
    parameter int RATIO_FRAC_BITS = DEF_RATIO_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // sequencing
    mwra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // storage and arithmetic
    mwra_dp #(
        .HISTORY_DEPTH   (HISTORY_DEPTH),
        .MAX_WINDOWS     (MAX_WINDOWS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule

[sim/testbench.sv]
// self-checking testbench for the multi-window ratio average
module testbench;
    import mwra_pkg::*;

    localparam int          CLK_PERIOD    = 8;
    localparam int          RESET_CYCLES  = 6;
    localparam int          IDLE_PCT      = 23;
    localparam int          RING_DEPTH    = DEF_HISTORY_DEPTH;
    localparam int          CONFIG_GAP    = 8;
    localparam int          SETTLE_CYCLES = 1000;
    localparam int          MAX_REPORTS   = 200;
    localparam longint      CYCLE_LIMIT   = 5000000;
    localparam logic [VAL_W-1:0] VAL_MAX  = '1;
    localparam logic [WIN_W-1:0] WIN_MAX  = '1;

    // block ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor copy of the sample history and the window settings
    logic [TIME_W-1:0]   hist_time  [RING_DEPTH];
    logic [VAL_W-1:0]    hist_ratio [RING_DEPTH];
    int unsigned         hist_wr;
    int unsigned         hist_fill;
    logic [TIME_W-1:0]   first_stamp;
    logic [WIN_W-1:0]    win_len [WIN_REGS];
    logic [WCOUNT_W-1:0] win_count;

    // window averages still owed by the block, oldest first
    t_out                pending_averages[$];
    t_out                oldest_average;

    int unsigned         failures = 0;
    int unsigned         reports  = 0;
    longint              cycles   = 0;
    logic                steady   = 1'b0;
    logic [TIME_W-1:0]   stamp    = '0;

    multi_window_ratio_average dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("multi_window_ratio_average verification failed");
            $finish;
        end
    end

    // count a failure, and allow a report while the log is still short
    function automatic bit count_failure();
        failures++;
        if (reports < MAX_REPORTS) begin
            reports++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // append one sample and work out the average for every window in use
    function automatic void predict_averages(input t_in item);
        logic [TIME_W-1:0] longest;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] age;
        logic [63:0]       sums [WIN_REGS];
        int unsigned       counts [WIN_REGS];
        logic [63:0]       mean;
        logic [63:0]       inv;
        int unsigned       n;
        int unsigned       slot;
        int unsigned       k;
        int unsigned       w;
        logic              zero_all;
        t_out              res;

        // a count of zero acts as one, large counts clamp
        n = 32'(win_count);
        if (n < 1) n = 1;
        if (n > WIN_REGS) n = WIN_REGS;
        if (n > DEF_MAX_WINDOWS) n = DEF_MAX_WINDOWS;

        // history ring update
        if (hist_fill == 0) first_stamp = item.sample_time;
        hist_time[hist_wr]  = item.sample_time;
        hist_ratio[hist_wr] = item.sample_ratio;
        hist_wr = (hist_wr + 1) % RING_DEPTH;
        if (hist_fill < RING_DEPTH) hist_fill++;

        longest = '0;
        for (w = 0; w < n; w++) begin
            sums[w]   = '0;
            counts[w] = 0;
            if (TIME_W'(win_len[w]) > longest) longest = TIME_W'(win_len[w]);
        end

        // walk back from the newest sample while inside the longest window
        zero_all = 1'b0;
        span = item.sample_time - first_stamp;
        if (span <= longest) begin
            zero_all = 1'b1;
        end else begin
            slot = (hist_wr + RING_DEPTH - 1) % RING_DEPTH;
            for (k = 0; k < hist_fill; k++) begin
                age = item.sample_time - hist_time[slot];
                if (age > longest) break;
                if (hist_ratio[slot] == '0) begin
                    zero_all = 1'b1;
                    break;
                end
                for (w = 0; w < n; w++) begin
                    if (age <= TIME_W'(win_len[w])) begin
                        sums[w] += 64'(hist_ratio[slot]);
                        counts[w]++;
                    end
                end
                slot = (slot + RING_DEPTH - 1) % RING_DEPTH;
            end
        end

        // floored mean and saturated reciprocal per window
        for (w = 0; w < n; w++) begin
            mean = '0;
            inv  = '0;
            if (!zero_all && counts[w] != 0) begin
                mean = sums[w] / 64'(counts[w]);
                if (mean > 64'(VAL_MAX)) mean = 64'(VAL_MAX);
                if (mean != 0) begin
                    inv = (64'd1 << (2 * DEF_RATIO_FRAC_BITS)) / mean;
                    if (inv > 64'(VAL_MAX)) inv = 64'(VAL_MAX);
                end
            end
            res.window_index = w[WIDX_W-1:0];
            res.mean_ratio   = mean[VAL_W-1:0];
            res.inverse_mean = inv[VAL_W-1:0];
            res.last_of_run  = (w + 1 == n);
            pending_averages.push_back(res);
        end
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got) begin
            if (count_failure()) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // result side: random back-pressure
    always @(negedge i_clk) begin
        i_out_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // compare every result transfer with the oldest pending average
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_averages.size() == 0) begin
                if (count_failure())
                    $error("result for window %0d with no sample pending", o_out.window_index);
            end else begin
                oldest_average = pending_averages.pop_front();
                check_field("window_index", VAL_W'(oldest_average.window_index),
                            VAL_W'(o_out.window_index));
                check_field("mean_ratio", oldest_average.mean_ratio, o_out.mean_ratio);
                check_field("inverse_mean", oldest_average.inverse_mean, o_out.inverse_mean);
                check_field("last_of_run", VAL_W'(oldest_average.last_of_run),
                            VAL_W'(o_out.last_of_run));
            end
        end
    end

    // one sample transfer, with an occasional gap in front of it
    task automatic send_sample(input logic [TIME_W-1:0] when, input logic [VAL_W-1:0] ratio);
        t_in item;
        item.sample_time  = when;
        item.sample_ratio = ratio;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 900)) @(negedge i_clk);
            else
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in       = item;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        predict_averages(item);
        stamp = when;
        @(negedge i_clk);
    endtask

    // hold off new samples until every pending average has come out
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending_averages.size() != 0) @(negedge i_clk);
        repeat (CONFIG_GAP) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_WINDOW_COUNT) win_count = data[WCOUNT_W-1:0];
        else win_len[idx[1:0]] = data;
    endtask

    task automatic set_windows(input logic [WIN_W-1:0] w0, input logic [WIN_W-1:0] w1,
                               input logic [WIN_W-1:0] w2, input logic [WIN_W-1:0] w3,
                               input logic [WCOUNT_W-1:0] count);
        write_reg(REG_WINDOW_0, w0);
        write_reg(REG_WINDOW_1, w1);
        write_reg(REG_WINDOW_2, w2);
        write_reg(REG_WINDOW_3, w3);
        write_reg(REG_WINDOW_COUNT, CFG_DATA_W'(count));
    endtask

    // mostly nonzero ratios, half of them below 4.0
    function automatic logic [VAL_W-1:0] random_ratio(input int unsigned zero_pct);
        logic [VAL_W-1:0] r;
        if ($urandom_range(0, 99) < zero_pct) return '0;
        if ($urandom_range(0, 1) == 1) r = VAL_W'($urandom_range(1, 32'h3FFFF));
        else r = VAL_W'($urandom);
        return (r == '0) ? VAL_W'(1) : r;
    endfunction

    // reset windows: history too short at first, then the boundary of window_0
    task automatic test_startup_not_ready();
        send_sample(32'd100, 24'h010000);
        send_sample(32'd130, 24'h000001);
        send_sample(32'd160, 24'h008000);
        send_sample(32'd161, VAL_MAX);
        send_sample(32'd161, 24'h000100);
    endtask

    // a zero ratio inside the window clears every result
    task automatic test_zero_ratio_walk();
        send_sample(32'd170, 24'h000000);
        send_sample(32'd175, 24'h020000);
        send_sample(32'd240, 24'h018000);
    endtask

    // zero and full-range windows, window count zero and seven
    task automatic test_window_extremes();
        set_windows('0, 16'd1, WIN_MAX, WIN_MAX, 3'd0);
        send_sample(32'd241, 24'h000001);
        send_sample(32'd241, VAL_MAX);
        write_reg(REG_WINDOW_COUNT, 16'd7);
        send_sample(32'd300, 24'h010000);
        send_sample(32'd70000, 24'h030000);
        send_sample(32'd70001, 24'h010000);
    endtask

    // timestamps that go backward and that wrap around
    task automatic test_time_wrap();
        write_reg(REG_WINDOW_COUNT, 16'd5);
        send_sample(32'd60, 24'h000800);
        send_sample(32'hFFFF_FFF0, 24'h012345);
        send_sample(32'h0000_0010, 24'h054321);
        write_reg(REG_WINDOW_COUNT, 16'd4);
        send_sample(32'h0000_0020, VAL_MAX);
    endtask

    // short windows with dense samples, first segment without any idling
    task automatic test_random_short_windows();
        int unsigned seg;
        int unsigned i;
        for (seg = 0; seg < 3; seg++) begin
            set_windows(WIN_W'($urandom_range(0, 200)), WIN_W'($urandom_range(0, 200)),
                        WIN_W'($urandom_range(0, 200)), WIN_W'($urandom_range(0, 200)),
                        3'(seg + 2));
            steady = (seg == 0);
            for (i = 0; i < 40; i++)
                send_sample(stamp + $urandom_range(0, 40), random_ratio(2));
            steady = 1'b0;
        end
    endtask

    // one window spans the whole ring, so the walk wraps after overflow
    task automatic test_random_full_ring();
        int unsigned i;
        set_windows(WIN_MAX, WIN_W'($urandom_range(0, 65535)),
                    WIN_W'($urandom_range(0, 2000)), WIN_W'($urandom_range(0, 300)), 3'd7);
        stamp = stamp + 32'd70000;
        for (i = 0; i < 200; i++) begin
            if (i == 100) drain_results();
            send_sample(stamp + $urandom_range(0, 300), random_ratio(0));
        end
    endtask

    // random windows and counts, with timestamp jumps in both directions
    task automatic test_random_noise();
        int unsigned seg;
        int unsigned i;
        for (seg = 0; seg < 3; seg++) begin
            set_windows(WIN_W'($urandom_range(0, 65535)), WIN_W'($urandom_range(0, 65535)),
                        WIN_W'($urandom_range(0, 65535)), WIN_W'($urandom_range(0, 65535)),
                        WCOUNT_W'($urandom_range(0, 7)));
            for (i = 0; i < 50; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_sample($urandom, random_ratio(1));
                else
                    send_sample(stamp + $urandom_range(0, 200), random_ratio(1));
            end
        end
    endtask

    initial begin
        win_len[0]  = WINDOW_0_RST;
        win_len[1]  = WINDOW_1_RST;
        win_len[2]  = WINDOW_2_RST;
        win_len[3]  = WINDOW_3_RST;
        win_count   = WINDOW_COUNT_RST;
        hist_wr     = 0;
        hist_fill   = 0;
        first_stamp = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_startup_not_ready();
        test_zero_ratio_walk();
        test_window_extremes();
        test_time_wrap();
        test_random_short_windows();
        test_random_full_ring();
        test_random_noise();

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending_averages.size() != 0) begin
            if (count_failure())
                $error("%0d window averages never came out", pending_averages.size());
        end
        if (failures == 0)
            $display("multi_window_ratio_average verification clean");
        else
            $display("multi_window_ratio_average verification failed");
        $finish;
    end

endmodule
